@@ rtl/dsf_pkg.sv @@
// Shared types, constants and the frame checksum function for the DShot frame generator.
// No dependencies; imported by dsf_seq and the top-level module.
`default_nettype none
package dsf_pkg;

  localparam int CHANNELS     = 4;
  localparam int FRAME_SLOTS  = 30;
  localparam int PATTERN_BITS = 16;
  localparam int CH_AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VAL_W        = 16;
  localparam int SLOT_W       = 6;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIT = 1'd1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_CHANNEL = 2'd1;
  localparam logic [1:0] ST_NOT_STARTED = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RW_CHK,
    S_LA_RD,
    S_LA_WR,
    S_TK_RD,
    S_TK_EMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] one_bit;
    logic [VAL_W-1:0] zero_bit;
  } cfg_regs_t;

  typedef struct packed {
    logic             we;
    logic [CH_AW-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [CH_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [VAL_W-1:0] frame_of(input logic [VAL_W-1:0] v);
    logic [3:0] sum;
    sum = v[3:0] ^ v[7:4] ^ v[11:8];
    return {v[11:0], sum};
  endfunction

endpackage
`default_nettype wire

@@ rtl/dsf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module dsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/dsf_seq.sv @@
// Item sequencer: read-modify-write of the value and pattern memories, frame slot
// counting, pattern latch sweeps and the result register. Depends on dsf_pkg.
`default_nettype none
module dsf_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_op,
  input  wire logic [2:0]                in_channel,
  input  wire logic [dsf_pkg::VAL_W-1:0] in_value,
  input  wire dsf_pkg::cfg_regs_t        cfg,
  output dsf_pkg::ram_req_t              lat_req,
  input  wire logic [dsf_pkg::VAL_W-1:0] lat_rdata,
  output dsf_pkg::ram_req_t              pat_req,
  input  wire logic [dsf_pkg::VAL_W-1:0] pat_rdata,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_status,
  output logic [2:0]                     out_channel_out,
  output logic [dsf_pkg::VAL_W-1:0]      out_read_value,
  output logic [dsf_pkg::VAL_W-1:0]      out_compare_value,
  output logic [dsf_pkg::SLOT_W-1:0]     out_slot,
  output logic                           out_last
);
  import dsf_pkg::*;

  localparam logic [CH_AW-1:0]  IDX_LAST  = CH_AW'(CHANNELS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_PAT  = SLOT_W'(PATTERN_BITS);

  state_t            state_r, state_nxt;
  logic [CH_AW-1:0]  idx_r;
  logic [SLOT_W-1:0] slot_r;
  logic              running_r, pending_r, latch_start_r;
  op_t               op_r;
  logic [CH_AW-1:0]  ch_r;
  logic [VAL_W-1:0]  val_r;
  logic [1:0]        res_status_r;
  logic [2:0]        res_ch_r;
  logic [VAL_W-1:0]  res_rv_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [2:0]        out_ch_r;
  logic [VAL_W-1:0]  out_rv_r, out_cv_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_last_r;

  logic              in_acc, out_free, in_bad, idx_last, slot_wrap, wr_changed;
  op_t               in_op_e;
  logic              tick_bit;
  logic [VAL_W-1:0]  tick_cv;

  logic              out_load;
  logic [1:0]        ld_status;
  logic [2:0]        ld_ch;
  logic [VAL_W-1:0]  ld_rv, ld_cv;
  logic [SLOT_W-1:0] ld_slot;
  logic              ld_last;

  assign in_op_e    = op_t'(in_op);
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign in_bad     = ({1'b0, in_channel} >= 4'(CHANNELS));
  assign idx_last   = (idx_r == IDX_LAST);
  assign slot_wrap  = (slot_r == SLOT_LAST);
  assign wr_changed = (op_r == OP_WRITE) && (lat_rdata != val_r);
  assign tick_bit   = pat_rdata[4'd15 - slot_r[3:0]];
  assign tick_cv    = (slot_r < SLOT_PAT) ? (tick_bit ? cfg.one_bit : cfg.zero_bit) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_op_e)
            OP_WRITE, OP_READ: state_nxt = in_bad ? S_EMIT : S_RW_CHK;
            OP_START:          state_nxt = running_r ? S_EMIT : S_LA_RD;
            OP_TICK:           state_nxt = running_r ? S_TK_RD : S_EMIT;
            default:           state_nxt = S_EMIT;
          endcase
        end
      end
      S_RW_CHK: state_nxt = S_EMIT;
      S_LA_RD:  state_nxt = S_LA_WR;
      S_LA_WR: begin
        if (idx_last) state_nxt = latch_start_r ? S_EMIT : S_IDLE;
        else          state_nxt = S_LA_RD;
      end
      S_TK_RD:  state_nxt = S_TK_EMIT;
      S_TK_EMIT: begin
        if (out_free) begin
          if (!idx_last)                   state_nxt = S_TK_RD;
          else if (slot_wrap && pending_r) state_nxt = S_LA_RD;
          else                             state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory requests and result load
  always_comb begin
    lat_req   = '0;
    pat_req   = '0;
    out_load  = 1'b0;
    ld_status = ST_OK;
    ld_ch     = '0;
    ld_rv     = '0;
    ld_cv     = '0;
    ld_slot   = '0;
    ld_last   = 1'b1;
    case (state_r)
      S_CLR: begin
        lat_req.we    = 1'b1;
        lat_req.waddr = idx_r;
        pat_req.we    = 1'b1;
        pat_req.waddr = idx_r;
      end
      S_IDLE: begin
        lat_req.re    = in_acc && !in_bad &&
                        (in_op_e == OP_WRITE || in_op_e == OP_READ);
        lat_req.raddr = in_channel[CH_AW-1:0];
      end
      S_RW_CHK: begin
        lat_req.we    = wr_changed;
        lat_req.waddr = ch_r;
        lat_req.wdata = val_r;
      end
      S_LA_RD: begin
        lat_req.re    = 1'b1;
        lat_req.raddr = idx_r;
      end
      S_LA_WR: begin
        pat_req.we    = 1'b1;
        pat_req.waddr = idx_r;
        pat_req.wdata = frame_of(lat_rdata);
      end
      S_TK_RD: begin
        pat_req.re    = 1'b1;
        pat_req.raddr = idx_r;
      end
      S_TK_EMIT: begin
        out_load = out_free;
        ld_ch    = 3'(idx_r);
        ld_cv    = tick_cv;
        ld_slot  = slot_r;
        ld_last  = idx_last;
      end
      S_EMIT: begin
        out_load  = out_free;
        ld_status = res_status_r;
        ld_ch     = res_ch_r;
        ld_rv     = res_rv_r;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      idx_r         <= '0;
      slot_r        <= '0;
      running_r     <= 1'b0;
      pending_r     <= 1'b0;
      latch_start_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLR: idx_r <= idx_last ? '0 : idx_r + 1'b1;
        S_IDLE: begin
          if (in_acc) begin
            idx_r         <= '0;
            latch_start_r <= (in_op_e == OP_START);
            if (in_op_e == OP_START && !running_r) begin
              running_r <= 1'b1;
              slot_r    <= '0;
            end
          end
        end
        S_RW_CHK: begin
          if (wr_changed) pending_r <= 1'b1;
        end
        S_LA_WR: begin
          idx_r <= idx_last ? '0 : idx_r + 1'b1;
          if (idx_last) pending_r <= 1'b0;
        end
        S_TK_EMIT: begin
          if (out_free) begin
            idx_r <= idx_last ? '0 : idx_r + 1'b1;
            if (idx_last) begin
              slot_r        <= slot_wrap ? '0 : slot_r + 1'b1;
              latch_start_r <= 1'b0;
            end
          end
        end
        default: begin
          idx_r <= idx_r;
        end
      endcase
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      op_r     <= in_op_e;
      ch_r     <= in_channel[CH_AW-1:0];
      val_r    <= in_value;
      res_rv_r <= '0;
      res_ch_r <= (in_op_e == OP_WRITE || in_op_e == OP_READ) ? in_channel : 3'd0;
      if ((in_op_e == OP_WRITE || in_op_e == OP_READ) && in_bad)
        res_status_r <= ST_BAD_CHANNEL;
      else if (in_op_e == OP_TICK && !running_r)
        res_status_r <= ST_NOT_STARTED;
      else
        res_status_r <= ST_OK;
    end
    if (state_r == S_RW_CHK && op_r == OP_READ) begin
      res_rv_r <= lat_rdata;
    end
    if (out_load) begin
      out_status_r <= ld_status;
      out_ch_r     <= ld_ch;
      out_rv_r     <= ld_rv;
      out_cv_r     <= ld_cv;
      out_slot_r   <= ld_slot;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_channel_out   = out_ch_r;
  assign out_read_value    = out_rv_r;
  assign out_compare_value = out_cv_r;
  assign out_slot          = out_slot_r;
  assign out_last          = out_last_r;

endmodule
`default_nettype wire

@@ rtl/dshot_multichannel_frame_generator.sv @@
// Top level of the DShot multichannel frame generator: configuration registers,
// value and pattern memories, sequencer. Depends on dsf_pkg, dsf_ram, dsf_seq.
//
// Usage: the input channel takes one command word at a time (write value, read
// value, start output, slot tick); in_stall stays high while a word is in work.
// Each word gives one result word on the output channel, a running slot tick one
// per motor channel in ascending order, out_last marking the final one.
// Steps per word: a write or read reads the value memory, then checks it (a write
// stores only a changed value) and emits; a channel out of range goes straight to
// its result. A start while running goes straight to its result; otherwise it
// latches the frame patterns in a pass that reads each value and writes its
// checksummed pattern. A tick while stopped goes straight to its result; a running
// tick reads and emits each channel's pattern, plus a latch pass at a frame end with
// pending values. Both memories have registered read data; each channel is read once per pass.
// Reset (rst_n low, synchronous) clears the compare registers and flags, then a
// clearing pass over every channel entry zeroes both memories with in_stall high.
// A stalled result holds in the output register and the sequencer waits on it;
// configuration writes (cfg_we) are taken at any edge outside reset.
`default_nettype none
module dshot_multichannel_frame_generator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic [2:0]                    in_channel,
  input  wire logic [dsf_pkg::VAL_W-1:0]     in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [2:0]                         out_channel_out,
  output logic [dsf_pkg::VAL_W-1:0]          out_read_value,
  output logic [dsf_pkg::VAL_W-1:0]          out_compare_value,
  output logic [dsf_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [dsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsf_pkg::VAL_W-1:0]     cfg_wdata
);
  import dsf_pkg::*;

  cfg_regs_t        cfg_r;
  ram_req_t         lat_req, pat_req;
  logic [VAL_W-1:0] lat_rdata, pat_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_BIT:  cfg_r.one_bit  <= cfg_wdata;
        CFG_ZERO_BIT: cfg_r.zero_bit <= cfg_wdata;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  dsf_ram #(.WIDTH(VAL_W), .DEPTH(CHANNELS), .AW(CH_AW)) u_lat_ram (
    .clk   (clk),
    .we    (lat_req.we),
    .waddr (lat_req.waddr),
    .wdata (lat_req.wdata),
    .re    (lat_req.re),
    .raddr (lat_req.raddr),
    .rdata (lat_rdata)
  );

  dsf_ram #(.WIDTH(VAL_W), .DEPTH(CHANNELS), .AW(CH_AW)) u_pat_ram (
    .clk   (clk),
    .we    (pat_req.we),
    .waddr (pat_req.waddr),
    .wdata (pat_req.wdata),
    .re    (pat_req.re),
    .raddr (pat_req.raddr),
    .rdata (pat_rdata)
  );

  dsf_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_channel        (in_channel),
    .in_value          (in_value),
    .cfg               (cfg_r),
    .lat_req           (lat_req),
    .lat_rdata         (lat_rdata),
    .pat_req           (pat_req),
    .pat_rdata         (pat_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_channel_out   (out_channel_out),
    .out_read_value    (out_read_value),
    .out_compare_value (out_compare_value),
    .out_slot          (out_slot),
    .out_last          (out_last)
  );

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while previous word in work");

  a_lat_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(lat_req.we && lat_req.re && lat_req.waddr == lat_req.raddr))
    else $error("value memory read and write to same entry");

  a_pat_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(pat_req.we && pat_req.re))
    else $error("pattern memory read during latch");

  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_STARTED || out_status == ST_BAD_CHANNEL)
      |-> out_last)
    else $error("error result not marked last");

endmodule
`default_nettype wire
